// File: hw/rtl/sppag_pkg.sv
// Shared constants and types of the strided permute page address generator.
// Used by sppag_decomp and strided_permute_page_address_gen_top.
`default_nettype none

package sppag_pkg;

   localparam int NUM_DIMS  = 4;
   localparam int MAX_RUN   = 64;

   localparam int LANE_W    = 16;
   localparam int CFG_W     = 64;
   localparam int IDX_W     = 32;
   localparam int OFF_W     = 34;
   localparam int PROD_W    = 2 * LANE_W;
   localparam int DIM_W     = 2;
   localparam int CNT_W     = $clog2(MAX_RUN + 1);

   localparam int DIV_BITS   = 4;
   localparam int DIV_STEPS  = IDX_W / DIV_BITS;
   localparam int DIV_SLOTS  = NUM_DIMS - 1;
   localparam int DIV_STAGES = DIV_SLOTS * DIV_STEPS;

   localparam logic [CFG_W-1:0] EXTENTS_RESET = 64'h0001_0001_0001_0001;

   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EXTENTS = 2'd0,
      CSR_STRIDES = 2'd1,
      CSR_PERM    = 2'd2
   } csr_index_type;

   typedef logic [DIV_SLOTS-1:0][LANE_W-1:0] lane_vec_type;

   typedef struct packed {
      logic         valid;
      lane_vec_type idx;
   } dcmp_type;

endpackage

`default_nettype wire

// File: hw/rtl/sppag_decomp.sv
// Pipelined mixed-radix decomposition of the group index, DIV_BITS quotient bits a stage.
// Depends on sppag_pkg.
`default_nettype none

module sppag_decomp
   import sppag_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              in_valid,
   input  wire logic [IDX_W-1:0]  in_index,
   input  wire lane_vec_type      divisors,
   output dcmp_type               out
);

   typedef struct packed {
      logic [IDX_W-1:0]  quo;
      logic [LANE_W-1:0] rem;
      lane_vec_type      idx;
   } stage_type;

   function automatic stage_type div_chunk(stage_type s, logic [LANE_W-1:0] dvs);
      logic [LANE_W:0] r2;
      stage_type       o;
      o = s;
      for (int b = 0; b < DIV_BITS; b++) begin
         r2 = {o.rem, o.quo[IDX_W-1]};
         if (r2 >= {1'b0, dvs}) begin
            o.rem = LANE_W'(r2 - {1'b0, dvs});
            o.quo = {o.quo[IDX_W-2:0], 1'b1};
         end else begin
            o.rem = r2[LANE_W-1:0];
            o.quo = {o.quo[IDX_W-2:0], 1'b0};
         end
      end
      return o;
   endfunction

   stage_type stage_ff [DIV_STAGES];
   stage_type stage_in [DIV_STAGES];
   logic      vld_ff   [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      localparam int  SLOT = s / DIV_STEPS;
      localparam bit  LAST = (s % DIV_STEPS) == (DIV_STEPS - 1);

      stage_type src;
      stage_type step;

      if (s == 0) begin : g_first
         always_comb begin
            src     = '0;
            src.quo = in_index;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[s] <= 1'b0;
            end else if (advance) begin
               vld_ff[s] <= in_valid;
            end
         end
      end else begin : g_next
         assign src = stage_ff[s-1];

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[s] <= 1'b0;
            end else if (advance) begin
               vld_ff[s] <= vld_ff[s-1];
            end
         end
      end

      always_comb begin
         step = div_chunk(src, divisors[SLOT]);
         stage_in[s] = step;
         if (LAST) begin
            stage_in[s].idx[SLOT] = step.rem;
            stage_in[s].rem       = '0;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign out.valid = vld_ff[DIV_STAGES-1];
   assign out.idx   = stage_ff[DIV_STAGES-1].idx;

endmodule

`default_nettype wire

// File: hw/rtl/strided_permute_page_address_gen_top.sv
// Top level of the strided permute page address generator: CSRs, products, sum and run emitter.
// Depends on sppag_pkg and sppag_decomp.
//
// A group index is taken whenever start is high and busy is low. The index goes through a
// 24-stage divider pipeline (four quotient bits a stage, three digits), one multiply stage
// and one sum stage into the emitter's offset register. A single run emitter then puts
// out one offset per cycle for the clamped permuted extent (1 to MAX_RUN offsets), with
// no gap between runs when the next sum waits. The emitter sets the sustained rate: it
// takes a new sum only on a run's last offset or while idle. rsp_strobe results cannot be
// held off; busy rises only while a finished sum waits for the emitter, and then the whole
// pipeline holds. CSRs are always ready and should be written only while the block is idle.
`default_nettype none

module strided_permute_page_address_gen_top
   import sppag_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 start,
   output      logic                 busy,
   input  wire logic [IDX_W-1:0]     req_group_index,

   output      logic                 rsp_strobe,
   output      logic [OFF_W-1:0]     rsp_page_offset,
   output      logic                 rsp_last_in_run,

   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_data
);

   logic [CFG_W-1:0]  extents_ff;
   logic [CFG_W-1:0]  strides_ff;
   logic [DIM_W-1:0]  perm_ff;

   logic [DIM_W-1:0]  xd_eff;
   lane_vec_type      divisors;
   logic [LANE_W-1:0] stride_x;
   logic [LANE_W-1:0] ext_x;
   logic [LANE_W-1:0] run_len;
   logic [CNT_W-1:0]  run_m1;
   logic [OFF_W-1:0]  stride_ext;

   logic              advance;
   logic              accept;
   dcmp_type          dcmp;

   logic                                mul_vld_ff;
   logic [DIV_SLOTS-1:0][PROD_W-1:0]    prod_ff;
   logic [DIV_SLOTS-1:0][PROD_W-1:0]    prod_in;
   logic                                sum_vld_ff;
   logic [OFF_W-1:0]                    base_ff;
   logic [OFF_W-1:0]                    base_in;

   logic              act_ff;
   logic              act_in;
   logic [OFF_W-1:0]  off_ff;
   logic [OFF_W-1:0]  off_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic              emit_last;
   logic              emit_free;
   logic              load;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         extents_ff <= EXTENTS_RESET;
         strides_ff <= '0;
         perm_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_EXTENTS: extents_ff <= csr_data;
            CSR_STRIDES: strides_ff <= csr_data;
            CSR_PERM:    perm_ff    <= csr_data[DIM_W-1:0];
            default:     ;
         endcase
      end
   end

   always_comb begin
      xd_eff   = perm_ff;
      if (32'(perm_ff) >= NUM_DIMS) begin
         xd_eff = DIM_W'(NUM_DIMS - 1);
      end
      stride_x = '0;
      ext_x    = '0;
      for (int d = 0; d < NUM_DIMS; d++) begin
         if (xd_eff == DIM_W'(d)) begin
            stride_x = strides_ff[d*LANE_W +: LANE_W];
            ext_x    = extents_ff[d*LANE_W +: LANE_W];
         end
      end
      for (int k = 0; k < DIV_SLOTS; k++) begin
         divisors[k] = extents_ff[(NUM_DIMS-2-k)*LANE_W +: LANE_W];
         if (xd_eff == DIM_W'(NUM_DIMS-2-k) || divisors[k] == '0) begin
            divisors[k] = LANE_W'(1);
         end
      end
   end

   always_comb begin
      run_len = (ext_x == '0) ? LANE_W'(1) : ext_x;
      if (run_len > LANE_W'(MAX_RUN)) begin
         run_len = LANE_W'(MAX_RUN);
      end
      run_m1     = CNT_W'(run_len - LANE_W'(1));
      stride_ext = OFF_W'(stride_x);
   end

   assign emit_last = act_ff && (cnt_ff == run_m1);
   assign emit_free = !act_ff || emit_last;
   assign load      = sum_vld_ff && emit_free;
   assign advance   = !sum_vld_ff || emit_free;
   assign busy      = !advance;
   assign accept    = start && !busy;

   sppag_decomp u_decomp (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (accept),
      .in_index (req_group_index),
      .divisors (divisors),
      .out      (dcmp)
   );

   always_comb begin
      for (int k = 0; k < DIV_SLOTS; k++) begin
         prod_in[k] = PROD_W'(dcmp.idx[k])
                    * PROD_W'(strides_ff[(NUM_DIMS-2-k)*LANE_W +: LANE_W]);
      end
   end

   always_comb begin
      base_in = '0;
      for (int k = 0; k < DIV_SLOTS; k++) begin
         base_in = base_in + OFF_W'(prod_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
         sum_vld_ff <= 1'b0;
      end else if (advance) begin
         mul_vld_ff <= dcmp.valid;
         sum_vld_ff <= mul_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         base_ff <= base_in;
      end
   end

   always_comb begin
      act_in = act_ff;
      off_in = off_ff;
      cnt_in = cnt_ff;
      priority if (load) begin
         act_in = 1'b1;
         off_in = base_ff;
         cnt_in = '0;
      end else if (emit_last) begin
         act_in = 1'b0;
      end else if (act_ff) begin
         off_in = off_ff + stride_ext;
         cnt_in = cnt_ff + CNT_W'(1);
      end else begin
         act_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
      end else begin
         act_ff <= act_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff <= off_in;
      cnt_ff <= cnt_in;
   end

   assign rsp_strobe      = act_ff;
   assign rsp_page_offset = off_ff;
   assign rsp_last_in_run = emit_last;

`ifndef SYNTHESIS
   a_run_step: assert property (@(posedge clock) disable iff (reset)
      (act_ff && !emit_last) |=>
         (act_ff && off_ff == $past(off_ff) + $past(stride_ext)
          && cnt_ff == $past(cnt_ff) + CNT_W'(1)))
      else $error("offset or count did not step within a run");

   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (emit_last && !sum_vld_ff) |=> !act_ff)
      else $error("emitter stayed active after the last offset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      busy |=> (sum_vld_ff && $stable(base_ff)))
      else $error("pending sum lost during stall");
`endif

endmodule

`default_nettype wire
